@@ src/text_console_cell_writer_macros.svh @@
// assertion macros for the console cell writer rtl, included by tcw_ctrl
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
// types, codes and constants of the text console cell writer
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int CURSOR_POS_W = 11;
    localparam int CELL_IDX_W  = 11;
    localparam int MEM_ADDR_W  = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [CHAR_W-1:0] CH_NULL    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } tcw_cmd_t;

    typedef enum logic {
        REG_BACK_COLOR = 1'b0,
        REG_TEXT_COLOR = 1'b1
    } tcw_reg_t;

    typedef struct packed {
        tcw_cmd_t                cmd;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_IDX_W-1:0]   cell_index;
    } tcw_item_t;

    typedef struct packed {
        logic [CURSOR_POS_W-1:0] cursor_pos;
        logic [CELL_W-1:0]       cell_data;
    } tcw_result_t;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [CELL_W-1:0]     wdata;
        logic                  re;
        logic [MEM_ADDR_W-1:0] raddr;
    } tcw_mem_req_t;

endpackage

@@ src/text_console_cell_writer.sv @@
// text console cell writer top level: config registers, sequencer and screen store
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  command   | start, busy            | item (cmd, char_code, cell_index)
//  result    | done (one-cycle beat)  | result (cursor_pos, cell_data)
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  printable, newline, return and null puts that do not scroll: result the cycle after the put is taken
//  read: passes through S_READ, as the read port of the screen store is registered
//  scroll: S_COPY moves rows up through the one store port pair, S_DRAIN, then S_BLANK blanks the last row
//  clear: one blank write per cell; after reset a blanking pass over every cell holds busy high
//  results cannot be stalled; done pulses for exactly one cycle per command
module text_console_cell_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tcw_item_t             item,
    output logic                  busy,
    output logic                  done,
    output tcw_result_t           result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [COLOR_W-1:0] back_color;
    logic [COLOR_W-1:0] text_color;
    tcw_mem_req_t       mem_req;
    logic [CELL_W-1:0]  mem_rdata;

    tcw_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .back_color (back_color),
        .text_color (text_color)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .back_color (back_color),
        .text_color (text_color),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    tcw_screen_ram #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

endmodule

@@ src/tcw_screen_ram.sv @@
// screen cell store: one write port, one registered read port
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int CELLS = DEF_COLUMNS * DEF_ROWS,
    parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
)
(
    input  logic              clk,
    input  tcw_mem_req_t      mem_req,
    output logic [CELL_W-1:0] mem_rdata
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr[AW-1:0]];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

@@ src/tcw_cfg_regs.sv @@
// colour registers behind the apb-style configuration port
module tcw_cfg_regs
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COLOR_W-1:0]    back_color,
    output logic [COLOR_W-1:0]    text_color
);

    logic [COLOR_W-1:0] back_color_reg;
    logic [COLOR_W-1:0] text_color_reg;
    tcw_reg_t           reg_sel;
    logic               wr_beat;

    assign reg_sel = tcw_reg_t'(paddr[2]);
    assign wr_beat = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_color_reg <= 4'd0;
            text_color_reg <= 4'd7;
        end
        else if (wr_beat)
        begin
            case (reg_sel)
                REG_BACK_COLOR: back_color_reg <= pwdata[COLOR_W-1:0];
                REG_TEXT_COLOR: text_color_reg <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BACK_COLOR: prdata = CFG_DATA_W'(back_color_reg);
            REG_TEXT_COLOR: prdata = CFG_DATA_W'(text_color_reg);
            default:        prdata = '0;
        endcase
    end

    assign back_color = back_color_reg;
    assign text_color = text_color_reg;

endmodule

@@ src/tcw_ctrl.sv @@
// cursor state, command sequencer and scroll/clear sweeps over the screen store
`include "text_console_cell_writer_macros.svh"
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int CELLS   = DEF_COLUMNS * DEF_ROWS,
    parameter int AW      = $clog2(DEF_COLUMNS * DEF_ROWS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tcw_item_t          item,
    output logic               busy,
    output logic               done,
    output tcw_result_t        result,
    input  logic [COLOR_W-1:0] back_color,
    input  logic [COLOR_W-1:0] text_color,
    output tcw_mem_req_t       mem_req,
    input  logic [CELL_W-1:0]  mem_rdata
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW0 = AW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_COPY,
        S_DRAIN,
        S_BLANK,
        S_READ
    } state_t;

    state_t                  state_reg, state_next;
    logic [RW-1:0]           row_reg, row_next;
    logic [CW-1:0]           col_reg, col_next;
    logic [AW-1:0]           ptr_reg, ptr_next;
    logic [AW-1:0]           wa_reg, wa_next;
    logic                    wpend_reg, wpend_next;
    logic                    ok_reg, ok_next;
    logic                    done_reg, done_next;
    logic [CURSOR_POS_W-1:0] pos_reg, pos_next;
    logic [CELL_W-1:0]       data_reg, data_next;
    logic [AW-1:0]           cur_addr;
    logic [AW-1:0]           lin_next;
    logic                    accept;

    assign accept   = start && (state_reg == S_IDLE);
    assign cur_addr = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign lin_next = AW'(row_next) * COLS_A + AW'(col_next);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ptr_next   = ptr_reg;
        wa_next    = wa_reg;
        wpend_next = wpend_reg;
        ok_next    = ok_reg;
        done_next  = 1'b0;
        data_next  = '0;
        mem_req    = '0;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_ADDR_W'(ptr_reg);
                mem_req.wdata = BLANK_CELL;
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                    done_next  = (state_reg == S_CLEAR);
                end
            end

            S_COPY:
            begin
                // read one row ahead, write the beat read last cycle
                mem_req.re    = 1'b1;
                mem_req.raddr = MEM_ADDR_W'(ptr_reg);
                mem_req.we    = wpend_reg;
                mem_req.waddr = MEM_ADDR_W'(wa_reg);
                mem_req.wdata = mem_rdata;
                wpend_next    = 1'b1;
                wa_next       = ptr_reg - COLS_A;
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_ADDR_W'(wa_reg);
                mem_req.wdata = mem_rdata;
                wpend_next    = 1'b0;
                ptr_next      = LAST_ROW0;
                state_next    = S_BLANK;
            end

            S_BLANK:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_ADDR_W'(ptr_reg);
                mem_req.wdata = BLANK_CELL;
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            S_READ:
            begin
                done_next  = 1'b1;
                data_next  = ok_reg ? mem_rdata : '0;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_PUT:
                        begin
                            done_next = 1'b1;
                            if (item.char_code == CH_NEWLINE)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    done_next  = 1'b0;
                                    wpend_next = 1'b0;
                                    ptr_next   = COLS_A;
                                    state_next = S_COPY;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else if (item.char_code == CH_RETURN)
                            begin
                                col_next = '0;
                            end
                            else if (item.char_code != CH_NULL)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = MEM_ADDR_W'(cur_addr);
                                mem_req.wdata = {back_color, text_color, item.char_code};
                                if (col_reg == LAST_COL)
                                begin
                                    // line end wraps like a newline
                                    col_next = '0;
                                    if (row_reg == LAST_ROW)
                                    begin
                                        done_next  = 1'b0;
                                        wpend_next = 1'b0;
                                        ptr_next   = COLS_A;
                                        state_next = S_COPY;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end

                        CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                        end

                        CMD_READ:
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = MEM_ADDR_W'(item.cell_index);
                            ok_next       = (32'(item.cell_index) < 32'(CELLS));
                            state_next    = S_READ;
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        pos_next = CURSOR_POS_W'(lin_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            ptr_reg   <= '0;
            wa_reg    <= '0;
            wpend_reg <= 1'b0;
            ok_reg    <= 1'b0;
            done_reg  <= 1'b0;
            pos_reg   <= '0;
            data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ptr_reg   <= ptr_next;
            wa_reg    <= wa_next;
            wpend_reg <= wpend_next;
            ok_reg    <= ok_next;
            done_reg  <= done_next;
            pos_reg   <= pos_next;
            data_reg  <= data_next;
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign result.cursor_pos = pos_reg;
    assign result.cell_data  = data_reg;

    `TCW_ASSERT_NEXT(a_read_done, state_reg == S_READ, done_reg, "read did not end in a beat")
    `TCW_ASSERT_IMP(a_row_range, 1'b1, 32'(row_reg) < ROWS, "cursor row off screen")
    `TCW_ASSERT_IMP(a_col_range, 1'b1, 32'(col_reg) < COLUMNS, "cursor column off screen")
    `TCW_ASSERT_IMP(a_write_range, mem_req.we, 32'(mem_req.waddr) < CELLS, "write past last cell")
    `TCW_ASSERT_IMP(a_beat_idle, done_reg, state_reg == S_IDLE, "beat while sweeping")

endmodule

@@ dv/text_console_cell_writer_tb.sv @@
// testbench for the text console cell writer: command beats, screen model and result checks
module text_console_cell_writer_tb
    import tcw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int COLUMNS         = DEF_COLUMNS;
    localparam int ROWS            = DEF_ROWS;
    localparam int CELLS           = COLUMNS * ROWS;
    localparam int REG_STRIDE      = 4;
    localparam int WATCHDOG_LIMIT  = 50000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 40;
    localparam int ITEMS_PER_PHASE = 560;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    tcw_item_t             item;
    logic                  busy;
    logic                  done;
    tcw_result_t           result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // screen model and queue of results still owed by the block
    logic [CELL_W-1:0]  screen_model [CELLS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COLOR_W-1:0] back_model;
    logic [COLOR_W-1:0] text_model;
    tcw_result_t        results_due [$];

    int errors;
    int idle_cycles;
    int sender_idle_pct;
    int items_sent;

    text_console_cell_writer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void blank_cells(int first, int count);
        for (int i = 0; i < count; i++)
            screen_model[first + i] = BLANK_CELL;
    endfunction

    function automatic void next_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            // scroll: every row moves up one, last row blanked
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_model[i] = screen_model[i + COLUMNS];
            blank_cells(CELLS - COLUMNS, COLUMNS);
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic tcw_result_t console_step(tcw_item_t it);
        tcw_result_t res;
        res.cell_data = '0;
        if (it.cmd == CMD_PUT)
        begin
            if (it.char_code == CH_NEWLINE)
                next_line();
            else if (it.char_code == CH_RETURN)
                cur_col = 0;
            else if (it.char_code != CH_NULL)
            begin
                screen_model[cur_row * COLUMNS + cur_col] = {back_model, text_model, it.char_code};
                cur_col++;
                if (cur_col >= COLUMNS)
                    next_line();
            end
        end
        else if (it.cmd == CMD_CLEAR)
        begin
            blank_cells(0, CELLS);
            cur_row = 0;
            cur_col = 0;
        end
        else if (it.cmd == CMD_READ)
        begin
            if (it.cell_index < CELLS)
                res.cell_data = screen_model[it.cell_index];
        end
        res.cursor_pos = CURSOR_POS_W'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    // checks result beats, predicts accepted commands, tracks register writes
    always @(posedge clk)
    begin
        tcw_result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (done)
            begin
                idle_cycles = 0;
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t unexpected result beat: expected none, actual pos %0d data %h",
                                 $time, result.cursor_pos, result.cell_data);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result.cursor_pos !== want.cursor_pos)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t cursor_pos mismatch: expected %0d, actual %0d",
                                     $time, want.cursor_pos, result.cursor_pos);
                    end
                    if (result.cell_data !== want.cell_data)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t cell_data mismatch: expected %h, actual %h",
                                     $time, want.cell_data, result.cell_data);
                    end
                end
            end
            if (start && !busy)
            begin
                idle_cycles = 0;
                results_due.push_back(console_step(item));
            end
            if (psel && penable && pwrite && pready)
            begin
                idle_cycles = 0;
                if (tcw_reg_t'(paddr[2]) == REG_BACK_COLOR)
                    back_model = pwdata[COLOR_W-1:0];
                else
                    text_model = pwdata[COLOR_W-1:0];
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one command beat; start stays high until the block takes it
    task automatic send_item(logic [1:0] cmd, logic [CHAR_W-1:0] ch,
                             logic [CELL_IDX_W-1:0] idx);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start           = 1'b1;
        item.cmd        = tcw_cmd_t'(cmd);
        item.char_code  = ch;
        item.cell_index = idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (cmd != CMD_UNUSED && !(cmd == CMD_PUT && ch == CH_NULL))
            items_sent++;
    endtask

    // register write, only once the block has nothing in flight
    task automatic write_reg(tcw_reg_t which, logic [COLOR_W-1:0] value);
        start = 1'b0;
        while (results_due.size() != 0 || busy)
            @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'(int'(which) * REG_STRIDE);
        pwdata  = ($urandom & ~32'hF) | CFG_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] printable_byte();
        logic [CHAR_W-1:0] b;
        do
            b = CHAR_W'($urandom_range(1, 255));
        while (b == CH_NEWLINE || b == CH_RETURN);
        return b;
    endfunction

    function automatic logic [CELL_IDX_W-1:0] cell_near_cursor();
        int unsigned row;
        case ($urandom_range(2))
            0: row = cur_row;
            1: row = (cur_row > 0) ? cur_row - 1 : 0;
            default: row = ROWS - 1;
        endcase
        return CELL_IDX_W'(row * COLUMNS + $urandom_range(COLUMNS - 1));
    endfunction

    task automatic test_after_reset();
        send_item(CMD_READ, 8'h00, '0);
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(CELLS - 1));
        send_item(CMD_READ, 8'hFF, '1);
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(CELLS));
        send_item(CMD_UNUSED, 8'h41, CELL_IDX_W'(5));
        send_item(CMD_PUT, CH_NULL, '1);
    endtask

    task automatic test_put_bytes();
        send_item(CMD_PUT, 8'h41, '0);
        send_item(CMD_PUT, 8'hFF, '0);
        send_item(CMD_PUT, 8'h80, '0);
        send_item(CMD_PUT, 8'h20, '0);
        send_item(CMD_PUT, CH_RETURN, '0);
        send_item(CMD_PUT, 8'h7F, '0);
        send_item(CMD_PUT, CH_NEWLINE, '0);
        send_item(CMD_PUT, 8'h01, '0);
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(0));
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(1));
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(2));
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(COLUMNS));
    endtask

    task automatic test_colors();
        write_reg(REG_BACK_COLOR, 4'hF);
        write_reg(REG_TEXT_COLOR, 4'h0);
        send_item(CMD_PUT, 8'h58, '0);
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(COLUMNS + 1));
        // clear blanks with the fixed blank cell, not the current colours
        send_item(CMD_CLEAR, 8'h00, '0);
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(0));
        write_reg(REG_BACK_COLOR, 4'h0);
        write_reg(REG_TEXT_COLOR, 4'hF);
        send_item(CMD_PUT, 8'h58, '0);
        send_item(CMD_READ, 8'h00, CELL_IDX_W'(0));
    endtask

    // lines of text with reads of what was written, newlines driving scrolls, plus clears, null and unused commands
    task automatic test_random_text(int idle_pct, logic [COLOR_W-1:0] back,
                                    logic [COLOR_W-1:0] text, int count);
        int target;
        int len;
        int pick;
        target = items_sent + count;
        write_reg(REG_BACK_COLOR, back);
        write_reg(REG_TEXT_COLOR, text);
        sender_idle_pct = idle_pct;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // long runs can reach the line end and wrap
                len = ($urandom_range(7) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
                repeat (len)
                    send_item(CMD_PUT, printable_byte(), CELL_IDX_W'($urandom));
                pick = $urandom_range(99);
                if (pick < 70)
                    send_item(CMD_PUT, CH_NEWLINE, CELL_IDX_W'($urandom));
                else if (pick < 85)
                    send_item(CMD_PUT, CH_RETURN, CELL_IDX_W'($urandom));
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(CMD_READ, CHAR_W'($urandom), cell_near_cursor());
            end
            else if (pick < 85)
                send_item(CMD_READ, CHAR_W'($urandom), CELL_IDX_W'($urandom));
            else if (pick < 87)
                send_item(CMD_CLEAR, CHAR_W'($urandom), CELL_IDX_W'($urandom));
            else if (pick < 93)
            begin
                case ($urandom_range(2))
                    0: send_item(CMD_PUT, CH_NULL, CELL_IDX_W'($urandom));
                    1: send_item(CMD_UNUSED, CHAR_W'($urandom), CELL_IDX_W'($urandom));
                    default: send_item(CMD_PUT, CHAR_W'($urandom), CELL_IDX_W'($urandom));
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_item(CMD_PUT, CH_NEWLINE, CELL_IDX_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        errors          = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        items_sent      = 0;
        blank_cells(0, CELLS);
        cur_row    = 0;
        cur_col    = 0;
        back_model = 4'h0;
        text_model = 4'h7;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_put_bytes();
        test_colors();
        test_random_text(0, 4'h0, 4'hF, ITEMS_PER_PHASE);
        test_random_text(68, 4'hF, 4'h0, ITEMS_PER_PHASE);
        test_random_text(32, COLOR_W'($urandom), COLOR_W'($urandom), ITEMS_PER_PHASE);

        start = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/tcw_cfg_regs.sv
src/tcw_ctrl.sv
src/text_console_cell_writer.sv
dv/text_console_cell_writer_tb.sv
